>>> hdl/pma_pkg.sv
// Shared types and constants of the particle moment accumulator.
`timescale 1ns / 1ps

package pma_pkg;

    localparam int unsigned CoordW = 24;
    localparam int unsigned SumW   = 64;

    localparam logic [1:0] CFG_ORIGIN_X = 2'd0;
    localparam logic [1:0] CFG_ORIGIN_Y = 2'd1;
    localparam logic [1:0] CFG_ORIGIN_Z = 2'd2;

    // One classified particle as it passes from the front end to the back end.
    typedef struct packed {
        logic              active;
        logic              last;
        logic [CoordW-1:0] mass;
        logic [CoordW-1:0] pos_x;
        logic [CoordW-1:0] pos_y;
        logic [CoordW-1:0] pos_z;
        logic [CoordW-1:0] vel_x;
        logic [CoordW-1:0] vel_y;
        logic [CoordW-1:0] vel_z;
    } particle_t;

    typedef struct packed {
        logic signed [SumW-1:0] total_mass;
        logic signed [SumW-1:0] com_x;
        logic signed [SumW-1:0] com_y;
        logic signed [SumW-1:0] com_z;
        logic signed [SumW-1:0] mom_x;
        logic signed [SumW-1:0] mom_y;
        logic signed [SumW-1:0] mom_z;
        logic signed [SumW-1:0] angmom_x;
        logic signed [SumW-1:0] angmom_y;
        logic signed [SumW-1:0] angmom_z;
        logic [SumW-2:0]        kinetic_energy;
        logic                   saturated;
    } totals_t;

    // Saturating signed add; the top bit of the result reports a clamp.
    function automatic logic [SumW:0] sat_add(input logic signed [SumW-1:0] a,
                                              input logic signed [SumW-1:0] b);
        logic signed [SumW:0] s;
        s = {a[SumW-1], a} + {b[SumW-1], b};
        if (s[SumW] != s[SumW-1])
            return {1'b1, s[SumW], {(SumW-1){~s[SumW]}}};
        return {1'b0, s[SumW-1:0]};
    endfunction

endpackage

>>> hdl/particle_moment_accumulator_top.sv
// Top level of the particle moment accumulator.
`timescale 1ns / 1ps

// Accumulates mass, centre of mass, momentum, angular momentum about the configured
// origin and kinetic energy over a run of particle beats, and emits one totals beat
// after the beat that carries tlast. A two-entry queue sits between the input side and
// the arithmetic. An active particle passes through the steps take, products, three shared
// angular-momentum multiplies and three sum updates; a skipped one is only taken. Closing a
// run adds three centre-of-mass divisions on a single bit-serial divider, and the totals
// then wait in place until taken.
module particle_moment_accumulator_top
#(
    parameter int unsigned FRAC_BITS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [23:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // mass, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
    input  logic [167:0] s_tdata,
    // is_tracer
    input  logic         s_tuser,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // total_mass, com_x, com_y, com_z, mom_x, mom_y, mom_z, angmom_x, angmom_y,
    // angmom_z, kinetic_energy (63), saturated
    output logic [703:0] m_tdata
);

    logic signed [23:0] org_x_reg;
    logic signed [23:0] org_y_reg;
    logic signed [23:0] org_z_reg;
    logic               q_valid;
    logic               q_pop;
    pma_pkg::particle_t q_item;
    pma_pkg::totals_t   res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_x_reg <= '0;
            org_y_reg <= '0;
            org_z_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pma_pkg::CFG_ORIGIN_X: org_x_reg <= cfg_data;
                pma_pkg::CFG_ORIGIN_Y: org_y_reg <= cfg_data;
                pma_pkg::CFG_ORIGIN_Z: org_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    pma_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    pma_back #(.FRAC_BITS(FRAC_BITS)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item),
        .origin_x  (org_x_reg),
        .origin_y  (org_y_reg),
        .origin_z  (org_z_reg),
        .res_valid (m_tvalid),
        .res_take  (m_tready),
        .res       (res)
    );

    assign m_tdata = {res.saturated, res.kinetic_energy, res.angmom_z, res.angmom_y,
                      res.angmom_x, res.mom_z, res.mom_y, res.mom_x, res.com_z,
                      res.com_y, res.com_x, res.total_mass};

endmodule

>>> hdl/pma_front.sv
// Front end: takes particle beats, classifies them and queues them for the back end.
`timescale 1ns / 1ps

module pma_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [167:0]        s_tdata,
    input  logic                s_tuser,
    input  logic                s_tlast,
    output logic                q_valid,
    input  logic                q_pop,
    output pma_pkg::particle_t  q_item
);

    pma_pkg::particle_t slot_reg [2];
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       rd_reg;
    logic       wr_reg;
    logic       push;
    pma_pkg::particle_t item;

    always_comb
    begin
        item.mass   = s_tdata[23:0];
        item.pos_x  = s_tdata[47:24];
        item.pos_y  = s_tdata[71:48];
        item.pos_z  = s_tdata[95:72];
        item.vel_x  = s_tdata[119:96];
        item.vel_y  = s_tdata[143:120];
        item.vel_z  = s_tdata[167:144];
        item.last   = s_tlast;
        item.active = (s_tdata[23:0] != '0) && !s_tuser;
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = slot_reg[rd_reg];
    assign cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wr_reg <= ~wr_reg;
            if (q_pop)
                rd_reg <= ~rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= item;
    end

endmodule

>>> hdl/pma_div.sv
// Restoring divider for the centre of mass, one quotient bit per cycle.
`timescale 1ns / 1ps

module pma_div
#(
    parameter int unsigned FRAC_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [63:0]  num,
    input  logic [63:0]         den,
    output logic                done,
    output logic signed [63:0]  quo
);

    localparam int unsigned QW = 64 + FRAC_BITS;
    localparam int unsigned CW = $clog2(QW + 1);

    logic [QW-1:0] n_reg;
    logic [QW-1:0] q_reg;
    logic [64:0]   r_reg;
    logic [63:0]   d_reg;
    logic          neg_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic [64:0]   r_shift;
    logic [64:0]   r_sub;
    logic [63:0]   mag;
    logic          big;

    assign mag     = num[63] ? (64'd0 - num) : num;
    assign r_shift = {r_reg[63:0], n_reg[QW-1]};
    assign r_sub   = r_shift - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(QW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg   <= {mag, {FRAC_BITS{1'b0}}};
            q_reg   <= '0;
            r_reg   <= '0;
            d_reg   <= den;
            neg_reg <= num[63];
        end
        else if (busy_reg)
        begin
            n_reg <= {n_reg[QW-2:0], 1'b0};
            if (!r_sub[64])
            begin
                r_reg <= r_sub;
                q_reg <= {q_reg[QW-2:0], 1'b1};
            end
            else
            begin
                r_reg <= r_shift;
                q_reg <= {q_reg[QW-2:0], 1'b0};
            end
        end
    end

    assign big = (q_reg[QW-1:63] != '0);

    always_comb
    begin
        if (neg_reg)
        begin
            if (big && !(q_reg[QW-1:64] == '0 && q_reg[62:0] == '0))
                quo = 64'sh8000_0000_0000_0000;
            else
                quo = 64'd0 - q_reg[63:0];
        end
        else if (big)
            quo = 64'sh7FFF_FFFF_FFFF_FFFF;
        else
            quo = q_reg[63:0];
    end

endmodule

>>> hdl/pma_back.sv
// Back end: product pipeline, saturating sums and the closing centre-of-mass division.
`timescale 1ns / 1ps

module pma_back
#(
    parameter int unsigned FRAC_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_pop,
    input  pma_pkg::particle_t   q_item,
    input  logic signed [23:0]   origin_x,
    input  logic signed [23:0]   origin_y,
    input  logic signed [23:0]   origin_z,
    output logic                 res_valid,
    input  logic                 res_take,
    output pma_pkg::totals_t     res
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PROD  = 3'd1;
    localparam logic [2:0] ST_TERM  = 3'd2;
    localparam logic [2:0] ST_ACC   = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_WAIT  = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    localparam logic signed [63:0] SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] SMIN = 64'sh8000_0000_0000_0000;

    // The rounded cross and square terms fit in XW signed bits, which bounds the
    // second-stage multipliers.
    localparam int unsigned XW = 50 - FRAC_BITS;
    localparam int unsigned PW = 25 + XW;

    logic [2:0] state_reg;
    logic [1:0] axis_reg;
    pma_pkg::particle_t it_reg;

    logic signed [63:0] cross_reg [3];
    logic signed [63:0] sq_reg;
    logic signed [63:0] term_reg [8];
    logic               tovf_reg;
    logic signed [63:0] msum_reg;
    logic signed [63:0] wsum_reg [3];
    logic signed [63:0] psum_reg [3];
    logic signed [63:0] lsum_reg [3];
    logic signed [63:0] esum_reg;
    logic               ovf_reg;
    logic signed [63:0] com_reg [3];

    logic signed [24:0] d [3];
    logic signed [23:0] v [3];
    logic signed [23:0] p [3];
    logic signed [24:0] m;
    logic               div_start;
    logic               div_done;
    logic signed [63:0] div_num;
    logic signed [63:0] div_quo;

    // Round half up by sh bits and clamp to 64 signed bits; bit 64 flags a clamp.
    function automatic logic [64:0] rnd(input logic signed [89:0] x, input int unsigned sh);
        logic signed [89:0] y;
        y = (x + (90'sd1 <<< (sh - 1))) >>> sh;
        if (y > 90'(SMAX))
            return {1'b1, SMAX};
        if (y < 90'(SMIN))
            return {1'b1, SMIN};
        return {1'b0, y[63:0]};
    endfunction

    always_comb
    begin
        m    = {1'b0, it_reg.mass};
        p[0] = it_reg.pos_x;
        p[1] = it_reg.pos_y;
        p[2] = it_reg.pos_z;
        v[0] = it_reg.vel_x;
        v[1] = it_reg.vel_y;
        v[2] = it_reg.vel_z;
        d[0] = 25'(p[0]) - 25'(origin_x);
        d[1] = 25'(p[1]) - 25'(origin_y);
        d[2] = 25'(p[2]) - 25'(origin_z);
    end

    assign q_pop     = (state_reg == ST_IDLE) && q_valid;
    assign div_num   = wsum_reg[axis_reg];
    assign div_start = (state_reg == ST_DIV);
    assign res_valid = (state_reg == ST_OUT);

    pma_div #(.FRAC_BITS(FRAC_BITS)) u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (msum_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    logic signed [48:0]   mp [3];
    logic signed [48:0]   mv [3];
    logic signed [PW-1:0] mc;
    logic signed [PW-1:0] ms;
    logic [64:0] r_tmp [8];
    logic [64:0] a_tmp [8];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mp[i] = 49'(m) * 49'(p[i]);
            mv[i] = 49'(m) * 49'(v[i]);
        end
        mc = PW'(m) * PW'($signed(cross_reg[axis_reg][XW-1:0]));
        ms = PW'(m) * PW'($signed(sq_reg[XW-1:0]));
        r_tmp[0] = rnd(90'(mp[0]), FRAC_BITS);
        r_tmp[1] = rnd(90'(mp[1]), FRAC_BITS);
        r_tmp[2] = rnd(90'(mp[2]), FRAC_BITS);
        r_tmp[3] = rnd(90'(mv[0]), FRAC_BITS);
        r_tmp[4] = rnd(90'(mv[1]), FRAC_BITS);
        r_tmp[5] = rnd(90'(mv[2]), FRAC_BITS);
        r_tmp[6] = rnd(90'(mc), FRAC_BITS);
        r_tmp[7] = rnd(90'(ms), FRAC_BITS + 1);
        a_tmp[0] = pma_pkg::sat_add(msum_reg, 64'(m));
        a_tmp[1] = pma_pkg::sat_add(wsum_reg[0], term_reg[0]);
        a_tmp[2] = pma_pkg::sat_add(wsum_reg[1], term_reg[1]);
        a_tmp[3] = pma_pkg::sat_add(wsum_reg[2], term_reg[2]);
        a_tmp[4] = pma_pkg::sat_add(psum_reg[0], term_reg[3]);
        a_tmp[5] = pma_pkg::sat_add(psum_reg[1], term_reg[4]);
        a_tmp[6] = pma_pkg::sat_add(psum_reg[2], term_reg[5]);
        a_tmp[7] = pma_pkg::sat_add(esum_reg, term_reg[7]);
    end

    logic [64:0] l_tmp;
    assign l_tmp = pma_pkg::sat_add(lsum_reg[axis_reg], cross_reg[axis_reg]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            axis_reg  <= '0;
            msum_reg  <= '0;
            esum_reg  <= '0;
            ovf_reg   <= 1'b0;
            tovf_reg  <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                wsum_reg[i] <= '0;
                psum_reg[i] <= '0;
                lsum_reg[i] <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                        state_reg <= q_item.active ? ST_PROD
                                   : (q_item.last ? ST_DIV : ST_IDLE);
                    axis_reg <= '0;
                end
                ST_PROD:
                    state_reg <= ST_TERM;
                ST_TERM:
                begin
                    // Angular momentum terms run one axis per cycle on a shared multiplier.
                    if (axis_reg == 2'd0)
                        tovf_reg <= r_tmp[0][64] | r_tmp[1][64] | r_tmp[2][64]
                                  | r_tmp[3][64] | r_tmp[4][64] | r_tmp[5][64]
                                  | r_tmp[6][64] | r_tmp[7][64];
                    else
                        tovf_reg <= tovf_reg | r_tmp[6][64];
                    if (axis_reg == 2'd2)
                    begin
                        axis_reg  <= '0;
                        state_reg <= ST_ACC;
                    end
                    else
                        axis_reg <= axis_reg + 1'b1;
                end
                ST_ACC:
                begin
                    lsum_reg[axis_reg] <= l_tmp[63:0];
                    if (axis_reg == 2'd0)
                    begin
                        msum_reg    <= a_tmp[0][63:0];
                        wsum_reg[0] <= a_tmp[1][63:0];
                        wsum_reg[1] <= a_tmp[2][63:0];
                        wsum_reg[2] <= a_tmp[3][63:0];
                        psum_reg[0] <= a_tmp[4][63:0];
                        psum_reg[1] <= a_tmp[5][63:0];
                        psum_reg[2] <= a_tmp[6][63:0];
                        esum_reg    <= a_tmp[7][63:0];
                        ovf_reg <= ovf_reg | tovf_reg | l_tmp[64] | a_tmp[0][64]
                                 | a_tmp[1][64] | a_tmp[2][64] | a_tmp[3][64]
                                 | a_tmp[4][64] | a_tmp[5][64] | a_tmp[6][64]
                                 | a_tmp[7][64];
                    end
                    else
                        ovf_reg <= ovf_reg | l_tmp[64];
                    if (axis_reg == 2'd2)
                    begin
                        axis_reg  <= '0;
                        state_reg <= it_reg.last ? ST_DIV : ST_IDLE;
                    end
                    else
                        axis_reg <= axis_reg + 1'b1;
                end
                ST_DIV:
                    state_reg <= ST_WAIT;
                ST_WAIT:
                begin
                    if (div_done)
                    begin
                        if (axis_reg == 2'd2)
                            state_reg <= ST_OUT;
                        else
                        begin
                            axis_reg  <= axis_reg + 1'b1;
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_OUT:
                begin
                    if (res_take)
                    begin
                        state_reg <= ST_IDLE;
                        axis_reg  <= '0;
                        msum_reg  <= '0;
                        esum_reg  <= '0;
                        ovf_reg   <= 1'b0;
                        for (int i = 0; i < 3; i++)
                        begin
                            wsum_reg[i] <= '0;
                            psum_reg[i] <= '0;
                            lsum_reg[i] <= '0;
                        end
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // Payload path: operand capture, products, rounded terms and the closing quotients.
    logic signed [49:0] cx [3];
    logic signed [48:0] vs;
    logic [64:0]        c_tmp [3];
    logic [64:0]        s_tmp;

    always_comb
    begin
        cx[0] = 50'(d[1]) * 50'(v[2]) - 50'(d[2]) * 50'(v[1]);
        cx[1] = 50'(d[2]) * 50'(v[0]) - 50'(d[0]) * 50'(v[2]);
        cx[2] = 50'(d[0]) * 50'(v[1]) - 50'(d[1]) * 50'(v[0]);
        vs    = 49'(v[0]) * 49'(v[0]) + 49'(v[1]) * 49'(v[1]) + 49'(v[2]) * 49'(v[2]);
        for (int i = 0; i < 3; i++)
            c_tmp[i] = rnd(90'(cx[i]), FRAC_BITS);
        s_tmp = rnd(90'(vs), FRAC_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            it_reg <= q_item;
        if (state_reg == ST_PROD)
        begin
            for (int i = 0; i < 3; i++)
                cross_reg[i] <= c_tmp[i][63:0];
            sq_reg <= s_tmp[63:0];
        end
        if (state_reg == ST_TERM)
        begin
            cross_reg[axis_reg] <= r_tmp[6][63:0];
            if (axis_reg == 2'd0)
                for (int i = 0; i < 8; i++)
                    term_reg[i] <= r_tmp[i][63:0];
        end
        if (state_reg == ST_WAIT && div_done)
            com_reg[axis_reg] <= (msum_reg == '0) ? '0 : div_quo;
    end

    always_comb
    begin
        res.total_mass     = msum_reg;
        res.com_x          = com_reg[0];
        res.com_y          = com_reg[1];
        res.com_z          = com_reg[2];
        res.mom_x          = psum_reg[0];
        res.mom_y          = psum_reg[1];
        res.mom_z          = psum_reg[2];
        res.angmom_x       = lsum_reg[0];
        res.angmom_y       = lsum_reg[1];
        res.angmom_z       = lsum_reg[2];
        res.kinetic_energy = esum_reg[62:0];
        res.saturated      = ovf_reg;
    end

endmodule
